// ===== hw/rtl/bma_pkg.sv =====
// Shared types and constants for the mosaic block averager.
// No dependencies; imported by bma_div, block_mosaic_average, block_mean_monitor and the testbench top.
package bma_pkg;

    localparam int CHANNEL_BITS_DEF     = 16;
    localparam int MAX_BLOCK_PIXELS_DEF = 65536;
    localparam int NUM_CH               = 4;
    localparam int TOTAL_W              = 17;
    localparam int CH_IDX_W             = $clog2(NUM_CH);

    // channel order in the accumulator and mean arrays
    localparam logic [CH_IDX_W-1:0] CH_RED   = 2'd0;
    localparam logic [CH_IDX_W-1:0] CH_GREEN = 2'd1;
    localparam logic [CH_IDX_W-1:0] CH_BLUE  = 2'd2;
    localparam logic [CH_IDX_W-1:0] CH_ALPHA = 2'd3;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FLUSH
    } bma_state_t;

endpackage

// ===== hw/rtl/bma_div.sv =====
// Restoring divider, one quotient bit per cycle, for the block averager.
// Depends on bma_pkg. Caller guarantees the quotient fits QUOT_W bits.
module bma_div #(
    parameter int QUOT_W = bma_pkg::CHANNEL_BITS_DEF,
    parameter int DEN_W  = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [QUOT_W+DEN_W-1:0] dividend,
    input  logic [DEN_W-1:0]        divisor,
    output logic                    done,
    output logic [QUOT_W-1:0]       quotient
);
    import bma_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W + 1);

    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] low_reg, low_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              qbit;

    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign qbit  = ~diff[DEN_W];

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            // top bits are already below the divisor, as the quotient fits
            rem_next  = dividend[QUOT_W+DEN_W-1:QUOT_W];
            low_next  = dividend[QUOT_W-1:0];
            step_next = STEP_W'(QUOT_W);
        end
        else if (step_reg != '0)
        begin
            rem_next  = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            low_next  = {low_reg[QUOT_W-2:0], qbit};
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// ===== hw/rtl/block_mosaic_average.sv =====
// Top level of the mosaic block averager: accumulators, sequencer, output register.
// Depends on bma_pkg and bma_div (shared divider used once per channel).
//
//  channel  signals                                       direction
//  pixel    in_valid/in_ready, pixel_*, last_pixel        into block
//  mean     out_valid/out_ready, mean_*, pixel_total      out of block
//
// Pixels without the last marker may stream back to back.
// After a last pixel the one divider runs one
// quotient bit a cycle for each of the four channels in turn; in_ready is low then.
// The result sits in an output register; the next block's pixels are taken while
// it waits, but a finished mean is held back until that register is free.
// Reset clears the accumulators, pixel count and valid flags.
module block_mosaic_average #(
    parameter int CHANNEL_BITS     = bma_pkg::CHANNEL_BITS_DEF,
    parameter int MAX_BLOCK_PIXELS = bma_pkg::MAX_BLOCK_PIXELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [CHANNEL_BITS-1:0]         pixel_red,
    input  logic [CHANNEL_BITS-1:0]         pixel_green,
    input  logic [CHANNEL_BITS-1:0]         pixel_blue,
    input  logic [CHANNEL_BITS-1:0]         pixel_alpha,
    input  logic                            last_pixel,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [CHANNEL_BITS-1:0]         mean_red,
    output logic [CHANNEL_BITS-1:0]         mean_green,
    output logic [CHANNEL_BITS-1:0]         mean_blue,
    output logic [CHANNEL_BITS-1:0]         mean_alpha,
    output logic [bma_pkg::TOTAL_W-1:0]     pixel_total
);
    import bma_pkg::*;

    localparam int COUNT_W = $clog2(MAX_BLOCK_PIXELS + 1);
    localparam int SUM_W   = CHANNEL_BITS + COUNT_W;

    bma_state_t state_reg, state_next;

    logic [SUM_W-1:0]        sum_reg [NUM_CH];
    logic [COUNT_W-1:0]      count_reg;
    logic [CH_IDX_W-1:0]     ch_reg;
    logic [CHANNEL_BITS-1:0] mean_work_reg [NUM_CH];
    logic [CHANNEL_BITS-1:0] pix [NUM_CH];

    logic                    out_valid_reg;
    logic [CHANNEL_BITS-1:0] mean_reg [NUM_CH];
    logic [TOTAL_W-1:0]      total_reg;

    logic                    in_xfer;
    logic                    block_full;
    logic                    div_start;
    logic                    div_done;
    logic                    load_out;
    logic [SUM_W-1:0]        div_dividend;
    logic [CHANNEL_BITS-1:0] div_quot;
    logic [COUNT_W+TOTAL_W-1:0] count_ext;

    assign pix[CH_RED]   = pixel_red;
    assign pix[CH_GREEN] = pixel_green;
    assign pix[CH_BLUE]  = pixel_blue;
    assign pix[CH_ALPHA] = pixel_alpha;

    assign in_xfer    = in_valid && in_ready;
    assign block_full = (count_reg >= COUNT_W'(MAX_BLOCK_PIXELS));
    // round half up: add half the count before dividing
    assign div_dividend = sum_reg[ch_reg] + SUM_W'(count_reg >> 1);
    assign count_ext    = {{TOTAL_W{1'b0}}, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                if (in_xfer && last_pixel)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (ch_reg == CH_IDX_W'(NUM_CH - 1)) ? ST_FLUSH : ST_DIV_START;
                end
            end
            ST_FLUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_ACC:       in_ready  = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_DIV_WAIT:  ;
            ST_FLUSH:     load_out  = !out_valid_reg || out_ready;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            count_reg     <= '0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (in_xfer && !block_full)
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    sum_reg[i] <= sum_reg[i] + SUM_W'(pix[i]);
                end
                count_reg <= count_reg + 1'b1;
            end
            else if (load_out)
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    sum_reg[i] <= '0;
                end
                count_reg <= '0;
            end

            if (in_xfer)
            begin
                ch_reg <= '0;
            end
            else if (div_done)
            begin
                ch_reg <= ch_reg + 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            mean_work_reg[ch_reg] <= div_quot;
        end
        if (load_out)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                mean_reg[i] <= mean_work_reg[i];
            end
            total_reg <= count_ext[TOTAL_W-1:0];
        end
    end

    bma_div #(
        .QUOT_W (CHANNEL_BITS),
        .DEN_W  (COUNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid   = out_valid_reg;
    assign mean_red    = mean_reg[CH_RED];
    assign mean_green  = mean_reg[CH_GREEN];
    assign mean_blue   = mean_reg[CH_BLUE];
    assign mean_alpha  = mean_reg[CH_ALPHA];
    assign pixel_total = total_reg;

endmodule

// ===== verif/block_mean_monitor.sv =====
// Channel monitor for block_mosaic_average: tracks pixel transfers, predicts block means
// and compares them with the mean transfers. Depends on bma_pkg; used by the testbench top.
module block_mean_monitor #(
    parameter int CHANNEL_BITS     = bma_pkg::CHANNEL_BITS_DEF,
    parameter int MAX_BLOCK_PIXELS = bma_pkg::MAX_BLOCK_PIXELS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [CHANNEL_BITS-1:0]      pixel_red,
    input  logic [CHANNEL_BITS-1:0]      pixel_green,
    input  logic [CHANNEL_BITS-1:0]      pixel_blue,
    input  logic [CHANNEL_BITS-1:0]      pixel_alpha,
    input  logic                         last_pixel,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [CHANNEL_BITS-1:0]      mean_red,
    input  logic [CHANNEL_BITS-1:0]      mean_green,
    input  logic [CHANNEL_BITS-1:0]      mean_blue,
    input  logic [CHANNEL_BITS-1:0]      mean_alpha,
    input  logic [bma_pkg::TOTAL_W-1:0]  pixel_total,
    output int                           errors,
    output int                           outstanding
);
    import bma_pkg::*;

    localparam int ACC_W = 64;

    typedef struct packed {
        logic [NUM_CH-1:0][CHANNEL_BITS-1:0] mean;
        logic [TOTAL_W-1:0]                  total;
    } block_mean_t;

    logic [ACC_W-1:0] chan_sum [NUM_CH];
    logic [31:0]      pixels_held;
    block_mean_t      pending_means [$];
    int               err_count;

    // round half up: floor((sum + floor(n/2)) / n)
    function automatic logic [CHANNEL_BITS-1:0] rounded_mean(input logic [ACC_W-1:0] sum,
                                                             input logic [31:0] count);
        logic [63:0] q;
        if (count == 0)
        begin
            return '0;
        end
        q = (64'(sum) + 64'(count >> 1)) / 64'(count);
        return q[CHANNEL_BITS-1:0];
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [CHANNEL_BITS-1:0] pix [NUM_CH];
        block_mean_t             fresh;
        block_mean_t             want;
        if (!rst_n)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                chan_sum[ch] = '0;
            end
            pixels_held = '0;
            pending_means.delete();
            err_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_means.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected mean transfer: expected none, %s %0d %0d %0d %0d %0d",
                             $time, "actual", mean_red, mean_green, mean_blue, mean_alpha,
                             pixel_total);
                end
                else
                begin
                    want = pending_means.pop_front();
                    check_field("mean_red", want.mean[CH_RED], mean_red);
                    check_field("mean_green", want.mean[CH_GREEN], mean_green);
                    check_field("mean_blue", want.mean[CH_BLUE], mean_blue);
                    check_field("mean_alpha", want.mean[CH_ALPHA], mean_alpha);
                    check_field("pixel_total", want.total, pixel_total);
                end
            end

            if (in_valid && in_ready)
            begin
                pix[CH_RED]   = pixel_red;
                pix[CH_GREEN] = pixel_green;
                pix[CH_BLUE]  = pixel_blue;
                pix[CH_ALPHA] = pixel_alpha;
                // a full block drops further pixels, the last marker still closes it
                if (pixels_held < MAX_BLOCK_PIXELS)
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        chan_sum[ch] = chan_sum[ch] + ACC_W'(pix[ch]);
                    end
                    pixels_held = pixels_held + 1;
                end
                if (last_pixel)
                begin
                    for (int ch = 0; ch < NUM_CH; ch++)
                    begin
                        fresh.mean[ch] = rounded_mean(chan_sum[ch], pixels_held);
                        chan_sum[ch] = '0;
                    end
                    fresh.total = pixels_held[TOTAL_W-1:0];
                    pending_means.push_back(fresh);
                    pixels_held = '0;
                end
            end
        end
        errors      <= err_count;
        outstanding <= pending_means.size();
    end

endmodule

// ===== verif/tb_block_mosaic_average.sv =====
// Testbench top for block_mosaic_average: drives pixel blocks and the mean ready line,
// runs a watchdog and gives the verdict. Depends on bma_pkg and block_mean_monitor.
module tb_block_mosaic_average;
    import bma_pkg::*;

    localparam int CB            = CHANNEL_BITS_DEF;
    localparam int BLOCK_MAX     = MAX_BLOCK_PIXELS_DEF;
    localparam int RANDOM_PIXELS = 450;
    localparam int NUM_PHASES    = 4;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 4 * (CB + 2) + 2 + 50;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic [CB-1:0]      pixel_red   = '0;
    logic [CB-1:0]      pixel_green = '0;
    logic [CB-1:0]      pixel_blue  = '0;
    logic [CB-1:0]      pixel_alpha = '0;
    logic               last_pixel  = 1'b0;
    logic               out_ready   = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [CB-1:0]      mean_red;
    logic [CB-1:0]      mean_green;
    logic [CB-1:0]      mean_blue;
    logic [CB-1:0]      mean_alpha;
    logic [TOTAL_W-1:0] pixel_total;

    int errors;
    int outstanding;
    int src_idle     = 0;
    int sink_stall   = 0;
    int quiet_cycles = 0;

    int phase_src  [NUM_PHASES] = '{0, 79, 0, 13};
    int phase_sink [NUM_PHASES] = '{0, 0, 79, 13};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    block_mosaic_average i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_red  (pixel_red),
        .pixel_green(pixel_green),
        .pixel_blue (pixel_blue),
        .pixel_alpha(pixel_alpha),
        .last_pixel (last_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mean_red   (mean_red),
        .mean_green (mean_green),
        .mean_blue  (mean_blue),
        .mean_alpha (mean_alpha),
        .pixel_total(pixel_total)
    );

    block_mean_monitor #(
        .CHANNEL_BITS    (CB),
        .MAX_BLOCK_PIXELS(BLOCK_MAX)
    ) i_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_red  (pixel_red),
        .pixel_green(pixel_green),
        .pixel_blue (pixel_blue),
        .pixel_alpha(pixel_alpha),
        .last_pixel (last_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .mean_red   (mean_red),
        .mean_green (mean_green),
        .mean_blue  (mean_blue),
        .mean_alpha (mean_alpha),
        .pixel_total(pixel_total),
        .errors     (errors),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall);
    end

    // cycles without any transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [CB-1:0] pick_level(input bit saturate);
        if (saturate)
        begin
            return '1;
        end
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return CB'($urandom);
        endcase
    endfunction

    // holds the pixel until its transfer, then maybe leaves the channel idle a while
    task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                              input logic [CB-1:0] b, input logic [CB-1:0] a,
                              input logic last);
        in_valid    <= 1'b1;
        pixel_red   <= r;
        pixel_green <= g;
        pixel_blue  <= b;
        pixel_alpha <= a;
        last_pixel  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        if (src_idle != 0 && $urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
    endtask

    task automatic send_block(input int len, input bit saturate);
        for (int i = 0; i < len; i++)
        begin
            send_pixel(pick_level(saturate), pick_level(saturate), pick_level(saturate),
                       pick_level(saturate), i == len - 1);
        end
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // single-pixel blocks at both ends of the range
        send_pixel('0, '0, '0, '0, 1'b1);
        send_pixel('1, '1, '1, '1, 1'b1);
        // exact halves round up
        send_pixel(16'd0, 16'd65535, 16'd0, 16'd1, 1'b0);
        send_pixel(16'd1, 16'd65534, 16'd65535, 16'd2, 1'b1);
        // thirds: one rounds down, one up
        send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_pixel(16'd0, 16'd1, 16'd1, 16'd1, 1'b0);
        send_pixel(16'd1, 16'd1, 16'd0, 16'd65535, 1'b1);
        send_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);
        send_pixel(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        // short saturated block
        send_block(8, 1'b1);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            src_idle   = phase_src[ph];
            sink_stall <= phase_sink[ph];
            sent = 0;
            while (sent < RANDOM_PIXELS / NUM_PHASES)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                send_block(len, 1'b0);
                sent += len;
            end
            if (ph == 1)
            begin
                // hold the pixel channel off until every mean has drained
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (outstanding != 0);
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bma_pkg.sv
hw/rtl/bma_div.sv
hw/rtl/block_mosaic_average.sv
verif/block_mean_monitor.sv
verif/tb_block_mosaic_average.sv
